// ----- rtl/gfpr_pkg.sv -----
// shared types, constants and field arithmetic for the gf(2^8) remainder unit
package gfpr_pkg;

    localparam int DATA_W         = 8;
    localparam int MAX_PARITY_DEF = 16;
    localparam int NUM_COEF       = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 64;
    localparam int PCOUNT_W       = 5;
    localparam int PCOUNT_RST     = 16;
    localparam logic [DATA_W-1:0] PRIM_RED_RST = 8'h1d;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PARITY_COUNT = 2'd0,
        CFG_GEN_LOW      = 2'd1,
        CFG_GEN_HIGH     = 2'd2,
        CFG_PRIM_POLY    = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [DATA_W-1:0] symbol;
        logic              last;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] parity_symbol;
        logic              last_parity;
    } t_out;

    // per-cell control from the top level
    typedef struct packed {
        logic step;    // symbol transaction this cycle
        logic clear;   // that symbol closes the block
        logic active;  // cell lies inside the current degree
        logic tail;    // cell takes the incoming symbol
        logic load;    // copy updated remainder into the drain row
        logic shift;   // drain row moves one place toward cell 0
    } t_cell_ctl;

    // carry-less product reduced by the low byte of the field polynomial
    function automatic logic [DATA_W-1:0] gf_mul(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b,
                                                 input logic [DATA_W-1:0] red);
        logic [DATA_W-1:0] acc;
        logic [DATA_W-1:0] sh;
        acc = '0;
        sh  = a;
        for (int k = 0; k < DATA_W; k++) begin
            if (b[k]) begin
                acc = acc ^ sh;
            end
            if (sh[DATA_W-1]) begin
                sh = {sh[DATA_W-2:0], 1'b0} ^ red;
            end else begin
                sh = {sh[DATA_W-2:0], 1'b0};
            end
        end
        return acc;
    endfunction

endpackage

// ----- rtl/gfpr_cell.sv -----
// one remainder cell: lfsr byte with its multiply-add, plus one drain byte
module gfpr_cell
    import gfpr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_top,
    input  logic [DATA_W-1:0] i_coef,
    input  logic [DATA_W-1:0] i_red,
    input  logic [DATA_W-1:0] i_next_rem,
    input  logic [DATA_W-1:0] i_sym,
    input  logic [DATA_W-1:0] i_next_out,
    output logic [DATA_W-1:0] o_rem,
    output logic [DATA_W-1:0] o_out
);

    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] n_rem;
    logic [DATA_W-1:0] r_out;
    logic [DATA_W-1:0] n_out;
    logic [DATA_W-1:0] w_prod;
    logic [DATA_W-1:0] w_feed;
    logic [DATA_W-1:0] w_stepped;

    assign w_prod    = gf_mul(i_top, i_coef, i_red);
    assign w_feed    = i_ctl.tail ? i_sym : i_next_rem;
    // cells past the degree keep their value
    assign w_stepped = i_ctl.active ? (w_feed ^ w_prod) : r_rem;

    always_comb begin
        n_rem = r_rem;
        if (i_ctl.step) begin
            n_rem = i_ctl.clear ? '0 : w_stepped;
        end
    end

    always_comb begin
        n_out = r_out;
        if (i_ctl.load) begin
            n_out = w_stepped;
        end else if (i_ctl.shift) begin
            n_out = i_next_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else begin
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_rem = r_rem;
    assign o_out = r_out;

endmodule

// ----- rtl/gf256_poly_remainder_unit.sv -----
// top level of the gf(2^8) polynomial remainder (reed-solomon parity) unit
//
// Dividend symbols stream in highest coefficient first, one transaction per
// cycle while the input is not stalled, and each one steps a row of
// MAX_PARITY cells that form the lfsr R = (R*x + d) mod g, one field
// multiply-add per cell per cycle with the feedback byte of cell 0 broadcast
// to all cells. On a symbol marked last the updated remainder is copied into
// a separate drain row and the lfsr cleared, so the next block can start in
// the following cycle while the parity bytes leave one per output
// transaction, highest degree first, the final one flagged. The drain row
// holds one remainder, so a last symbol waits while an earlier remainder
// still has more than one byte to deliver, or while its final byte is stalled.
// Configuration (degree, generator coefficients, field polynomial) must be
// written by the user only while the unit is idle; the unit itself does not
// enforce this. A degree of 0 acts as 1 and one above MAX_PARITY acts as MAX_PARITY.
module gf256_poly_remainder_unit
    import gfpr_pkg::*;
#(
    parameter int MAX_PARITY = MAX_PARITY_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // symbol input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in,
    // parity output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int CNT_W   = $clog2(MAX_PARITY + 1);
    localparam int RST_DEG = (PCOUNT_RST > MAX_PARITY) ? MAX_PARITY : PCOUNT_RST;
    localparam logic [PCOUNT_W:0] MAX_DEG = (PCOUNT_W + 1)'(MAX_PARITY);

    // configuration registers
    logic [CNT_W-1:0]      r_deg;
    logic [CFG_DATA_W-1:0] r_gen_low;
    logic [CFG_DATA_W-1:0] r_gen_high;
    logic [DATA_W-1:0]     r_red;
    logic [PCOUNT_W-1:0]   w_pcount;
    logic [PCOUNT_W:0]     w_deg_clamp;

    // handshake and drain control
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic                  w_out_acc;
    logic                  w_load_ok;
    logic                  w_in_acc;
    logic                  w_load;

    // cell chains, one extra zero entry past the end
    logic [MAX_PARITY:0][DATA_W-1:0] w_rem;
    logic [MAX_PARITY:0][DATA_W-1:0] w_out;

    // clamp the degree once at write time
    assign w_pcount = i_cfg_wdata[PCOUNT_W-1:0];
    always_comb begin
        if (w_pcount == '0) begin
            w_deg_clamp = (PCOUNT_W + 1)'(1);
        end else if ({1'b0, w_pcount} > MAX_DEG) begin
            w_deg_clamp = MAX_DEG;
        end else begin
            w_deg_clamp = {1'b0, w_pcount};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg      <= CNT_W'(RST_DEG);
            r_gen_low  <= '0;
            r_gen_high <= '0;
            r_red      <= PRIM_RED_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_PARITY_COUNT: r_deg      <= CNT_W'(w_deg_clamp);
                CFG_GEN_LOW:      r_gen_low  <= i_cfg_wdata;
                CFG_GEN_HIGH:     r_gen_high <= i_cfg_wdata;
                CFG_PRIM_POLY:    r_red      <= i_cfg_wdata[DATA_W-1:0];
                default:          r_red      <= r_red;
            endcase
        end
    end

    // the drain row can take a new remainder when empty or emptying now
    assign o_out_valid = (r_cnt != '0);
    assign w_out_acc   = o_out_valid && !i_out_stall;
    assign w_load_ok   = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && w_out_acc);
    assign o_in_stall  = i_in.last && !w_load_ok;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_load      = w_in_acc && i_in.last;

    always_comb begin
        n_cnt = r_cnt;
        if (w_load) begin
            n_cnt = r_deg;
        end else if (w_out_acc) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    assign w_rem[MAX_PARITY] = '0;
    assign w_out[MAX_PARITY] = '0;

    // the lfsr row and drain row
    for (genvar g = 0; g < MAX_PARITY; g++) begin : g_cell
        t_cell_ctl         w_ctl;
        logic [DATA_W-1:0] w_coef;

        // cell g uses generator coefficient g+1; none beyond sixteen
        if (g < NUM_COEF / 2) begin : g_lo
            assign w_coef = r_gen_low[DATA_W*g +: DATA_W];
        end else if (g < NUM_COEF) begin : g_hi
            assign w_coef = r_gen_high[DATA_W*(g - NUM_COEF/2) +: DATA_W];
        end else begin : g_zero
            assign w_coef = '0;
        end

        assign w_ctl.step   = w_in_acc;
        assign w_ctl.clear  = i_in.last;
        assign w_ctl.active = (CNT_W'(g) < r_deg);
        assign w_ctl.tail   = (CNT_W'(g + 1) == r_deg);
        assign w_ctl.load   = w_load;
        assign w_ctl.shift  = w_out_acc;

        gfpr_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_top      (w_rem[0]),
            .i_coef     (w_coef),
            .i_red      (r_red),
            .i_next_rem (w_rem[g+1]),
            .i_sym      (i_in.symbol),
            .i_next_out (w_out[g+1]),
            .o_rem      (w_rem[g]),
            .o_out      (w_out[g])
        );
    end

    assign o_out.parity_symbol = w_out[0];
    assign o_out.last_parity   = (r_cnt == CNT_W'(1));

`ifndef NO_ASSERTIONS
    // a closing symbol leaves the lfsr row cleared
    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (w_rem[MAX_PARITY-1:0] == '0))
        else $error("remainder not cleared after last symbol");

    // the drain count never exceeds the configured degree
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_deg)
        else $error("drain count above degree");

    // a load always starts a full drain
    a_load_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_out_valid && (r_cnt == $past(r_deg))))
        else $error("drain not started with full degree");

    // the closing symbol is only taken when the drain row is free
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (r_cnt != '0)) |-> (r_cnt == CNT_W'(1)) && w_out_acc)
        else $error("remainder loaded over undelivered parity");
`endif

endmodule
